// File: sv/tcpq_pkg.sv
// Shared types and constants for the two-class priority queue.
// No dependencies; imported by every module of the block.
`default_nettype none

package tcpq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 64;
   localparam int PTR_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int OCC_W      = 5;

   // request codes (code 3 also dequeues)
   localparam logic [1:0] REQ_NORMAL      = 2'd0;
   localparam logic [1:0] REQ_URGENT      = 2'd1;
   localparam logic [1:0] REQ_DEQUEUE     = 2'd2;
   localparam logic [1:0] REQ_DEQUEUE_ALT = 2'd3;

   // response status codes
   localparam logic [1:0] ST_ENQUEUED = 2'd0;
   localparam logic [1:0] ST_DATA     = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [63:0] item_data;
   } req_word_type;

   typedef struct packed {
      logic [63:0]      out_data;
      logic [1:0]       status;
      logic [OCC_W-1:0] occupancy;
   } rsp_word_type;

   typedef struct packed {
      logic load;   // capture request word
      logic exec;   // perform ring update and memory access
   } ctl_cmd_type;

endpackage

`default_nettype wire

// File: sv/tcpq_ctrl.sv
// Sequencer for the priority queue: one request at a time through
// capture, execute and respond. Depends on tcpq_pkg.
`default_nettype none

module tcpq_ctrl
   import tcpq_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   output ctl_cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_EXEC = 3'b010,
      S_RESP = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign cmd.load  = req_valid && (state_ff == S_IDLE);
   assign cmd.exec  = (state_ff == S_EXEC);

endmodule

`default_nettype wire

// File: sv/tcpq_datapath.sv
// Datapath: request register, urgent and normal rings with their pointers
// and counts, registered memory reads and the response word. Uses tcpq_pkg.
`default_nettype none

module tcpq_datapath
   import tcpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire ctl_cmd_type  cmd,
   input  wire req_word_type req_word,
   output rsp_word_type      rsp_word
);

   req_word_type req_ff;

   logic [DATA_WIDTH-1:0] urg_mem [DEPTH];
   logic [DATA_WIDTH-1:0] nrm_mem [DEPTH];

   logic [PTR_W-1:0] urg_head_ff, urg_head_in, urg_tail_ff, urg_tail_in;
   logic [PTR_W-1:0] nrm_head_ff, nrm_head_in, nrm_tail_ff, nrm_tail_in;
   logic [CNT_W-1:0] urg_cnt_ff, urg_cnt_in, nrm_cnt_ff, nrm_cnt_in;

   logic [DATA_WIDTH-1:0] urg_rd_ff, nrm_rd_ff;
   logic                  sel_urg_ff;
   logic [1:0]            status_ff, status_in;
   logic [OCC_W-1:0]      occ_ff;

   logic             is_deq, is_full;
   logic             deq_urg, deq_nrm, enq_urg, enq_nrm;
   logic [CNT_W:0]   total_now, total_next;

   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] pos);
      ring_next = (pos == PTR_W'(DEPTH - 1)) ? '0 : pos + 1'b1;
   endfunction

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_word;
   end

   assign is_deq = (req_ff.req_type == REQ_DEQUEUE) ||
                   (req_ff.req_type == REQ_DEQUEUE_ALT);
   assign total_now = {1'b0, urg_cnt_ff} + {1'b0, nrm_cnt_ff};
   assign is_full   = (total_now >= (CNT_W + 1)'(DEPTH));

   assign deq_urg = is_deq && (urg_cnt_ff != '0);
   assign deq_nrm = is_deq && (urg_cnt_ff == '0) && (nrm_cnt_ff != '0);
   assign enq_urg = !is_deq && !is_full && (req_ff.req_type == REQ_URGENT);
   assign enq_nrm = !is_deq && !is_full && (req_ff.req_type == REQ_NORMAL);

   always_comb begin
      urg_head_in = urg_head_ff;
      urg_tail_in = urg_tail_ff;
      urg_cnt_in  = urg_cnt_ff;
      nrm_head_in = nrm_head_ff;
      nrm_tail_in = nrm_tail_ff;
      nrm_cnt_in  = nrm_cnt_ff;
      if (deq_urg) begin
         urg_head_in = ring_next(urg_head_ff);
         urg_cnt_in  = urg_cnt_ff - 1'b1;
      end
      if (deq_nrm) begin
         nrm_head_in = ring_next(nrm_head_ff);
         nrm_cnt_in  = nrm_cnt_ff - 1'b1;
      end
      if (enq_urg) begin
         urg_tail_in = ring_next(urg_tail_ff);
         urg_cnt_in  = urg_cnt_ff + 1'b1;
      end
      if (enq_nrm) begin
         nrm_tail_in = ring_next(nrm_tail_ff);
         nrm_cnt_in  = nrm_cnt_ff + 1'b1;
      end
      if (is_deq) begin
         status_in = (deq_urg || deq_nrm) ? ST_DATA : ST_EMPTY;
      end else begin
         status_in = is_full ? ST_FULL : ST_ENQUEUED;
      end
   end

   assign total_next = {1'b0, urg_cnt_in} + {1'b0, nrm_cnt_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         urg_head_ff <= '0;
         urg_tail_ff <= '0;
         urg_cnt_ff  <= '0;
         nrm_head_ff <= '0;
         nrm_tail_ff <= '0;
         nrm_cnt_ff  <= '0;
      end else if (cmd.exec) begin
         urg_head_ff <= urg_head_in;
         urg_tail_ff <= urg_tail_in;
         urg_cnt_ff  <= urg_cnt_in;
         nrm_head_ff <= nrm_head_in;
         nrm_tail_ff <= nrm_tail_in;
         nrm_cnt_ff  <= nrm_cnt_in;
      end
   end

   // ring memories: one write, one registered read each
   always_ff @(posedge clock) begin
      if (cmd.exec && enq_urg) urg_mem[urg_tail_ff] <= req_ff.item_data[DATA_WIDTH-1:0];
      if (cmd.exec && deq_urg) urg_rd_ff <= urg_mem[urg_head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec && enq_nrm) nrm_mem[nrm_tail_ff] <= req_ff.item_data[DATA_WIDTH-1:0];
      if (cmd.exec && deq_nrm) nrm_rd_ff <= nrm_mem[nrm_head_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         sel_urg_ff <= deq_urg;
         status_ff  <= status_in;
         occ_ff     <= OCC_W'(total_next);
      end
   end

   always_comb begin
      rsp_word.out_data = '0;
      if (status_ff == ST_DATA) begin
         rsp_word.out_data = 64'(sel_urg_ff ? urg_rd_ff : nrm_rd_ff);
      end
      rsp_word.status    = status_ff;
      rsp_word.occupancy = occ_ff;
   end

endmodule

`default_nettype wire

// File: sv/two_class_priority_queue_core.sv
// Two-class priority queue, top level.
// Channels: req_ (request word: req_type, item_data) and rsp_ (response
// word: out_data, status, occupancy), both valid/ready; a word moves when
// valid and ready are high at a rising clock edge.
// req_type 0 appends a normal word, 1 appends a priority word behind all
// priority words held and ahead of every normal one, 2 or 3 dequeues the
// front word. status: 0 enqueued, 1 data valid, 2 empty, 3 full; out_data
// is zero unless status is 1. occupancy is the count held after the request.
// Timing: the request is captured in S_IDLE, the rings update in S_EXEC, and
// rsp_valid is high in S_RESP until the response is taken.
// The three-state sequencer handles one request at a time (capture, ring
// update with registered memory read, respond); a new request is not taken
// until the response to the last one has been taken.
// Reset (synchronous, active high) empties both rings at once; no clearing
// pass. While rsp_ready is low the response word holds and req_ready stays
// low until it is taken.
// Depends on tcpq_pkg, tcpq_ctrl, tcpq_datapath.
`default_nettype none

module two_class_priority_queue_core
   import tcpq_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_word_type req_word,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_word_type      rsp_word
);

   ctl_cmd_type cmd;

   tcpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   tcpq_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

endmodule

`default_nettype wire
